FILE: design/fbwa_pkg.sv
// Shared types and constants for the fit-policy partition allocator.
// No dependencies; fbwa_front, fbwa_back and the top level import this package.
package fbwa_pkg;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_NEXT  = 2'd3
  } fit_mode_e;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } back_state_e;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    op_e  op;
    logic idx_ok;
  } cmd_ctrl_t;

  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 4'd1;

  localparam int unsigned PIDX_W = 4;
  localparam int unsigned AMOUNT_W = 16;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned EXT_W = 9;

  localparam fit_mode_e           FIT_MODE_RESET   = FIT_FIRST;
  localparam logic [COUNT_W-1:0] PART_COUNT_RESET = 5'd16;

endpackage

FILE: design/fbwa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fbwa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/fbwa_front.sv
// Front end: accepts input transactions, classifies them and queues them.
// Depends on fbwa_pkg.
module fbwa_front import fbwa_pkg::*; #(
  parameter int unsigned NUM_PARTITIONS = 16,
  parameter int unsigned SIZE_BITS = 16,
  localparam int unsigned IW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 in_func_i,
  input  logic [PIDX_W-1:0]    in_index_i,
  input  logic [AMOUNT_W-1:0]  in_amount_i,
  output logic                 cmd_valid_o,
  output cmd_ctrl_t            cmd_ctrl_o,
  output logic [IW-1:0]        cmd_idx_o,
  output logic [SIZE_BITS-1:0] cmd_want_o,
  input  logic                 cmd_pop_i
);

  localparam int unsigned QDEPTH = 2;

  cmd_ctrl_t            ctrl_q [QDEPTH];
  logic [IW-1:0]        idx_q  [QDEPTH];
  logic [SIZE_BITS-1:0] want_q [QDEPTH];
  logic                 wr_ptr_q, wr_ptr_d;
  logic                 rd_ptr_q, rd_ptr_d;
  logic [1:0]           fill_q, fill_d;

  cmd_ctrl_t            ctrl_new;
  logic [EXT_W-1:0]     idx_ext;
  logic                 push;
  logic                 pop;

  // Classify: decode the operation and check the load index against the table.
  always_comb begin
    idx_ext         = EXT_W'(in_index_i);
    ctrl_new.op     = op_e'(in_func_i);
    ctrl_new.idx_ok = (idx_ext < EXT_W'(NUM_PARTITIONS));
  end

  assign in_ready_o  = (fill_q != 2'(QDEPTH));
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_ctrl_o  = ctrl_q[rd_ptr_q];
  assign cmd_idx_o   = idx_q[rd_ptr_q];
  assign cmd_want_o  = want_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ctrl_q[wr_ptr_q] <= ctrl_new;
      idx_q[wr_ptr_q]  <= idx_ext[IW-1:0];
      want_q[wr_ptr_q] <= SIZE_BITS'(in_amount_i);
    end
  end

endmodule

FILE: design/fbwa_back.sv
// Back end: executes loads and scans the partition table for requests.
// Depends on fbwa_pkg and fbwa_ram.
module fbwa_back import fbwa_pkg::*; #(
  parameter int unsigned NUM_PARTITIONS = 16,
  parameter int unsigned SIZE_BITS = 16,
  localparam int unsigned IW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1,
  localparam int unsigned CW = $clog2(NUM_PARTITIONS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fit_mode_e            fit_mode_i,
  input  logic [COUNT_W-1:0]   part_count_i,
  input  logic                 cmd_valid_i,
  input  cmd_ctrl_t            cmd_ctrl_i,
  input  logic [IW-1:0]        cmd_idx_i,
  input  logic [SIZE_BITS-1:0] cmd_want_i,
  output logic                 cmd_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 out_granted_o,
  output logic [PIDX_W-1:0]    out_index_o
);

  back_state_e          state_q, state_d;
  logic [IW-1:0]        pos_q, pos_d;
  logic [IW-1:0]        start_q, start_d;
  logic [CW-1:0]        remain_q, remain_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [IW-1:0]        cmp_pos_q, cmp_pos_d;
  logic                 found_q, found_d;
  logic [IW-1:0]        pick_q, pick_d;
  logic [SIZE_BITS-1:0] best_q, best_d;
  logic [SIZE_BITS-1:0] want_q, want_d;
  fit_mode_e            mode_q, mode_d;
  logic [IW-1:0]        ptr_q, ptr_d;
  logic [NUM_PARTITIONS-1:0] used_q, used_d;
  logic                 out_vld_q, out_vld_d;
  logic                 out_granted_q, out_granted_d;
  logic [PIDX_W-1:0]    out_idx_q, out_idx_d;

  logic [EXT_W-1:0]     cnt_ext;
  logic [CW-1:0]        cnt;
  logic [IW-1:0]        start;
  logic [CW-1:0]        pos_inc;
  logic [IW-1:0]        pos_next;
  logic [SIZE_BITS-1:0] rdata;
  logic                 ram_we;
  logic                 fits;
  logic                 take;
  logic [EXT_W-1:0]     pick_ext;

  fbwa_ram #(
    .WIDTH(SIZE_BITS),
    .DEPTH(NUM_PARTITIONS)
  ) u_size_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cmd_idx_i),
    .wdata_i(cmd_want_i),
    .raddr_i(pos_q),
    .rdata_o(rdata)
  );

  // A count beyond the table is clamped to the table size.
  always_comb begin
    cnt_ext = (EXT_W'(part_count_i) > EXT_W'(NUM_PARTITIONS)) ?
              EXT_W'(NUM_PARTITIONS) : EXT_W'(part_count_i);
    cnt     = cnt_ext[CW-1:0];
    start   = ((fit_mode_i == FIT_NEXT) && (CW'(ptr_q) < cnt)) ? ptr_q : '0;
    pos_inc = CW'(pos_q) + CW'(1);
    pos_next = (pos_inc == cnt) ? '0 : pos_inc[IW-1:0];
    fits    = !used_q[cmp_pos_q] && (rdata >= want_q);
    unique case (mode_q)
      FIT_BEST:  take = fits && (!found_q || (rdata < best_q));
      FIT_WORST: take = fits && (!found_q || (rdata > best_q));
      default:   take = fits && !found_q;
    endcase
    pick_ext = EXT_W'(pick_q);
  end

  always_comb begin
    state_d       = state_q;
    pos_d         = pos_q;
    start_d       = start_q;
    remain_d      = remain_q;
    cmp_vld_d     = 1'b0;
    cmp_pos_d     = cmp_pos_q;
    found_d       = found_q;
    pick_d        = pick_q;
    best_d        = best_q;
    want_d        = want_q;
    mode_d        = mode_q;
    ptr_d         = ptr_q;
    used_d        = used_q;
    out_vld_d     = out_vld_q && !out_ready_i;
    out_granted_d = out_granted_q;
    out_idx_d     = out_idx_q;
    cmd_pop_o     = 1'b0;
    ram_we        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_ctrl_i.op == OP_LOAD) begin
            ptr_d = '0;
            if (cmd_ctrl_i.idx_ok) begin
              ram_we            = 1'b1;
              used_d[cmd_idx_i] = 1'b0;
            end
          end else begin
            want_d   = cmd_want_i;
            mode_d   = fit_mode_i;
            found_d  = 1'b0;
            start_d  = start;
            pos_d    = start;
            remain_d = cnt;
            state_d  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Issue one read per cycle; each compare runs in the cycle after its read.
        if (remain_q != '0) begin
          cmp_vld_d = 1'b1;
          cmp_pos_d = pos_q;
          pos_d     = pos_next;
          remain_d  = remain_q - CW'(1);
        end
        if (cmp_vld_q && take) begin
          found_d = 1'b1;
          pick_d  = cmp_pos_q;
          best_d  = rdata;
        end
        if ((remain_q == '0) && !cmp_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_d     = 1'b1;
          out_granted_d = found_q;
          out_idx_d     = found_q ? pick_ext[PIDX_W-1:0] : '0;
          if (found_q) begin
            used_d[pick_q] = 1'b1;
          end
          if (mode_q == FIT_NEXT) begin
            ptr_d = found_q ? pick_q : start_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      remain_q  <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      ptr_q     <= '0;
      used_q    <= '1;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      remain_q  <= remain_d;
      cmp_vld_q <= cmp_vld_d;
      found_q   <= found_d;
      ptr_q     <= ptr_d;
      used_q    <= used_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q         <= pos_d;
    start_q       <= start_d;
    cmp_pos_q     <= cmp_pos_d;
    pick_q        <= pick_d;
    best_q        <= best_d;
    want_q        <= want_d;
    mode_q        <= mode_d;
    out_granted_q <= out_granted_d;
    out_idx_q     <= out_idx_d;
  end

  assign out_valid_o   = out_vld_q;
  assign out_granted_o = out_granted_q;
  assign out_index_o   = out_idx_q;

endmodule

FILE: design/fit_policy_block_allocator_top.sv
// Top level of the fit-policy partition allocator.
// Depends on fbwa_pkg, fbwa_front, fbwa_back and fbwa_ram.
//
// Usage:
// The slave stream carries commands. tuser is the operation (0 loads a
// partition size, 1 requests an allocation); tdata holds the partition index
// and the amount. A load writes the size, marks the partition free and
// returns the next-fit pointer to zero; it produces no result transaction.
// Each request produces exactly one master-stream transaction with a grant
// flag and the granted index (zero when nothing fits).
// The configuration channel writes the fit mode (index 0) and the number of
// partitions in use (index 1). It is always ready and should only be used
// while no command is in flight.
// Operation: a load is executed as the back end takes the command. A request
// takes the command, then reads the size memory once per partition, up to
// the clamped partition count (no reads when the count is zero), with each
// compare trailing its read; it then finishes the trailing compare, leaves
// the scan and commits. The back end takes no new command until the
// request is committed; the size memory has separate read and write ports.
// A two-entry command queue sits in front of the back end, so the slave side
// keeps accepting while a search runs or a result waits. When the receiver
// stalls, the result is held in the output register and the back end stops
// before its commit cycle; the queue then fills and tready drops.
// After reset every partition is marked used, the pointer is zero, the mode
// is first fit and the count is 16. The size memory is not cleared; a
// partition only becomes free once a load has written its size.
module fit_policy_block_allocator_top import fbwa_pkg::*; #(
  parameter int unsigned NUM_PARTITIONS = 16,
  parameter int unsigned SIZE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Command stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata from bit 0: partition_index[3:0], amount[19:4], zero pad [23:20].
  input  logic [23:0]           s_axis_tdata,
  // tuser from bit 0: func.
  input  logic                  s_axis_tuser,
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata from bit 0: granted[0], granted_index[4:1], zero pad [7:5].
  output logic [7:0]            m_axis_tdata,
  // Configuration writes.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;

  fit_mode_e            fit_mode_q;
  logic [COUNT_W-1:0]   part_count_q;

  logic                 cmd_valid;
  cmd_ctrl_t            cmd_ctrl;
  logic [IW-1:0]        cmd_idx;
  logic [SIZE_BITS-1:0] cmd_want;
  logic                 cmd_pop;
  logic                 out_granted;
  logic [PIDX_W-1:0]    out_index;

  // Configuration registers; writes to unknown indices are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q   <= FIT_MODE_RESET;
      part_count_q <= PART_COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_FIT_MODE) begin
        fit_mode_q <= fit_mode_e'(cfg_data_i[1:0]);
      end else if (cfg_index_i == CFG_PART_COUNT) begin
        part_count_q <= cfg_data_i[COUNT_W-1:0];
      end
    end
  end

  fbwa_front #(
    .NUM_PARTITIONS(NUM_PARTITIONS),
    .SIZE_BITS     (SIZE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_func_i  (s_axis_tuser),
    .in_index_i (s_axis_tdata[3:0]),
    .in_amount_i(s_axis_tdata[19:4]),
    .cmd_valid_o(cmd_valid),
    .cmd_ctrl_o (cmd_ctrl),
    .cmd_idx_o  (cmd_idx),
    .cmd_want_o (cmd_want),
    .cmd_pop_i  (cmd_pop)
  );

  fbwa_back #(
    .NUM_PARTITIONS(NUM_PARTITIONS),
    .SIZE_BITS     (SIZE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fit_mode_i   (fit_mode_q),
    .part_count_i (part_count_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_ctrl_i   (cmd_ctrl),
    .cmd_idx_i    (cmd_idx),
    .cmd_want_i   (cmd_want),
    .cmd_pop_o    (cmd_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_granted_o(out_granted),
    .out_index_o  (out_index)
  );

  assign m_axis_tdata = {3'b000, out_index, out_granted};

endmodule
